>>> src/tea_pkg.sv
// tea_pkg: shared types, constants and the round-sum helper for the tea block cipher
// no dependencies; compiled before every other file of the block
package tea_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned ROUNDS_DEF  = 32;
	localparam logic [31:0] TEA_DELTA   = 32'h9E37_79B9;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 2'd3;

	// direction codes
	localparam logic KIND_ENC = 1'b0;
	localparam logic KIND_DEC = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t k0;
		word_t k1;
		word_t k2;
		word_t k3;
	} tea_key_t;

	typedef struct packed {
		logic  kind;
		word_t y;
		word_t z;
	} tea_blk_t;

	// delta * n mod 2^32, evaluated at elaboration only
	function automatic word_t tea_sum(input int unsigned n);
		logic [63:0] p;
		p = 64'(TEA_DELTA) * 64'(n);
		return p[WORD_W-1:0];
	endfunction

endpackage

>>> src/tea_if.sv
// tea_in_if / tea_out_if: valid-ready channels carrying blocks in and results out
// depends on tea_pkg for the word type
interface tea_in_if;
	import tea_pkg::*;
	logic  valid;
	logic  ready;
	logic  kind;
	word_t first_word;
	word_t second_word;

	modport source (output valid, output kind, output first_word, output second_word,
		input ready);
	modport sink (input valid, input kind, input first_word, input second_word,
		output ready);
endinterface

interface tea_out_if;
	import tea_pkg::*;
	logic  valid;
	logic  ready;
	word_t out_first_word;
	word_t out_second_word;

	modport source (output valid, output out_first_word, output out_second_word,
		input ready);
	modport sink (input valid, input out_first_word, input out_second_word,
		output ready);
endinterface

>>> src/tea_block_cipher.sv
// tea_block_cipher: fully pipelined tea encrypt/decrypt engine, 128-bit key in registers
// depends on tea_pkg, tea_if (tea_in_if, tea_out_if) and tea_half_round
//
//  channel   dir  fields                               moves
//  in_ch     in   kind, first_word, second_word        one block request
//  out_ch    out  out_first_word, out_second_word      one result block
//  wr_*      in   wr_en, wr_index, wr_data             one key word write
//
// one half round per stage: 2*ROUNDS stages. a block can be taken every cycle unless the
// pipe is frozen by a stall; throughput is one block per cycle while it is not frozen.
// the last stage is the output register; when it holds an untaken result the whole
// pipe freezes, empty stages included, and the input is held off, so nothing is dropped
// or duplicated.
// reset clears the stage valid bits and the key words to zero.
module tea_block_cipher #(
	parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tea_in_if.sink                        in_ch,
	tea_out_if.source                     out_ch,
	input  logic                          wr_en,
	input  logic [tea_pkg::CFG_IDX_W-1:0] wr_index,
	input  tea_pkg::word_t                wr_data
);
	import tea_pkg::*;

	localparam int unsigned STAGES = 2 * ROUNDS;

	tea_key_t key_q;
	logic     en;
	logic     vld [STAGES+1];
	tea_blk_t blk [STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_KEY0: key_q.k0 <= wr_data;
				REG_KEY1: key_q.k1 <= wr_data;
				REG_KEY2: key_q.k2 <= wr_data;
				REG_KEY3: key_q.k3 <= wr_data;
				default:  key_q    <= key_q;
			endcase
		end
	end

	// pipe advances unless a finished result is still waiting
	assign en          = !vld[STAGES] || out_ch.ready;
	assign in_ch.ready = en;

	assign vld[0]      = in_ch.valid;
	assign blk[0].kind = in_ch.kind;
	assign blk[0].y    = in_ch.first_word;
	assign blk[0].z    = in_ch.second_word;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		tea_half_round #(
			.SECOND  (k % 2 == 1),
			.ENC_SUM (tea_sum(k / 2 + 1)),
			.DEC_SUM (tea_sum(ROUNDS - k / 2))
		) u_half (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.key    (key_q),
			.vld_in (vld[k]),
			.blk_in (blk[k]),
			.vld_s1 (vld[k+1]),
			.blk_s1 (blk[k+1])
		);
	end

	assign out_ch.valid           = vld[STAGES];
	assign out_ch.out_first_word  = blk[STAGES].y;
	assign out_ch.out_second_word = blk[STAGES].z;

endmodule

>>> src/tea_half_round.sv
// tea_half_round: one registered half round of tea, either direction
// depends on tea_pkg; instantiated 2*ROUNDS times by tea_block_cipher
module tea_half_round #(
	parameter bit          SECOND = 1'b0,   // second half of its round
	parameter logic [31:0] ENC_SUM = 32'h0,
	parameter logic [31:0] DEC_SUM = 32'h0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tea_pkg::tea_key_t key,
	input  logic             vld_in,
	input  tea_pkg::tea_blk_t blk_in,
	output logic             vld_s1,
	output tea_pkg::tea_blk_t blk_s1
);
	import tea_pkg::*;

	logic     upd_y;
	word_t    w;
	word_t    tgt;
	word_t    ka;
	word_t    kb;
	word_t    s;
	word_t    mix;
	word_t    res;
	tea_blk_t nxt;

	// encrypt: y then z; decrypt: z then y
	assign upd_y = (SECOND == 1'b0) ^ (blk_in.kind == KIND_DEC);

	always_comb begin
		w   = upd_y ? blk_in.z : blk_in.y;
		tgt = upd_y ? blk_in.y : blk_in.z;
		ka  = upd_y ? key.k0 : key.k2;
		kb  = upd_y ? key.k1 : key.k3;
		s   = (blk_in.kind == KIND_DEC) ? DEC_SUM : ENC_SUM;
		mix = ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
		res = (blk_in.kind == KIND_DEC) ? (tgt - mix) : (tgt + mix);
		nxt = blk_in;
		if (upd_y) begin
			nxt.y = res;
		end else begin
			nxt.z = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_s1 <= nxt;
		end
	end

endmodule

>>> src/tea_checker.sv
// tea_checker: port-level assertions for tea_block_cipher, attached by bind
// depends on tea_pkg for the word type; sees only the top level's ports
module tea_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input tea_pkg::word_t out_first_word,
	input tea_pkg::word_t out_second_word
);
	import tea_pkg::*;

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// the pipe takes a request exactly when its output register can move
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	// a frozen pipe keeps its result intact
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_first_word) && $stable(out_second_word))
		else $error("stalled result changed");

	// nothing comes out while in reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result during reset");

endmodule

bind tea_block_cipher tea_checker u_tea_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_first_word  (out_ch.out_first_word),
	.out_second_word (out_ch.out_second_word)
);

>>> tb/tea_block_cipher_tb.sv
// tea_block_cipher_tb: checks the pipelined tea engine against a cycle-free software predictor
// depends on tea_pkg, tea_in_if / tea_out_if and tea_block_cipher
// directed table first, then random blocks in phases with new keys, bursty requests and stalls
module tea_block_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tea_pkg::*;

	localparam int unsigned N_ROUNDS   = ROUNDS_DEF;
	localparam int unsigned PIPE_LAT   = 2 * N_ROUNDS;
	localparam int unsigned HOLD_OFF   = 300;
	localparam int unsigned PHASE_BLKS = 108;
	localparam int unsigned N_PHASES   = 6;

	typedef struct packed {
		word_t y;
		word_t z;
	} blk_out_t;

	typedef struct {
		bit       set_key;
		tea_key_t key;
		logic     kind;
		word_t    y;
		word_t    z;
		bit       typed;
		word_t    ey;
		word_t    ez;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	word_t wr_data;

	tea_in_if  in_ch ();
	tea_out_if out_ch ();

	tea_block_cipher i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	blk_out_t cipher_q[$];
	tea_key_t key_shadow;
	dir_row_t dir_tab[$];

	int unsigned fails;
	int unsigned blocks_sent;
	int unsigned dec_sent;
	int unsigned results_seen;
	int unsigned key_loads;
	int unsigned in_stall_cycles;
	int unsigned burst_left;
	bit src_gaps;
	bit sink_free;
	bit hold_off_req;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tea_block_cipher_tb failed");
		$finish;
	end

	// one tea half round mix term
	function automatic word_t tea_mix(word_t w, word_t ka, word_t kb, word_t sum);
		return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
	endfunction

	function automatic blk_out_t tea_cipher(logic kind, word_t y, word_t z, tea_key_t k);
		word_t sum;
		word_t acc_y;
		word_t acc_z;
		acc_y = y;
		acc_z = z;
		sum = '0;
		if (kind == KIND_ENC) begin
			for (int r = 0; r < N_ROUNDS; r++) begin
				sum += TEA_DELTA;
				acc_y += tea_mix(acc_z, k.k0, k.k1, sum);
				acc_z += tea_mix(acc_y, k.k2, k.k3, sum);
			end
		end else begin
			repeat (N_ROUNDS) sum += TEA_DELTA;
			for (int r = 0; r < N_ROUNDS; r++) begin
				acc_z -= tea_mix(acc_y, k.k2, k.k3, sum);
				acc_y -= tea_mix(acc_z, k.k0, k.k1, sum);
				sum -= TEA_DELTA;
			end
		end
		return '{y: acc_y, z: acc_z};
	endfunction

	// mostly random words, with a share of all-zero, all-one, single-bit and single-zero-bit patterns
	function automatic word_t pick_word();
		word_t w;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			2: w = word_t'(1) << $urandom_range(0, WORD_W - 1);
			3: w = ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic tea_key_t pick_key();
		return '{k0: pick_word(), k1: pick_word(), k2: pick_word(), k3: pick_word()};
	endfunction

	function automatic dir_row_t blk_row(logic kind, word_t y, word_t z, bit typed = 1'b0,
		word_t ey = '0, word_t ez = '0);
		return '{set_key: 1'b0, key: '0, kind: kind, y: y, z: z, typed: typed, ey: ey, ez: ez};
	endfunction

	function automatic dir_row_t key_row(word_t k0, word_t k1, word_t k2, word_t k3);
		return '{set_key: 1'b1, key: '{k0: k0, k1: k1, k2: k2, k3: k3}, kind: KIND_ENC,
			y: '0, z: '0, typed: 1'b0, ey: '0, ez: '0};
	endfunction

	// offer one block request and hold it until taken; called and returns at a rising edge
	task automatic send_block(logic kind, word_t y, word_t z, bit typed, word_t ey, word_t ez);
		in_ch.valid       <= 1'b1;
		in_ch.kind        <= kind;
		in_ch.first_word  <= y;
		in_ch.second_word <= z;
		do @(negedge clk); while (!in_ch.ready);
		if (typed)
			cipher_q.push_back('{y: ey, z: ez});
		else
			cipher_q.push_back(tea_cipher(kind, y, z, key_shadow));
		blocks_sent++;
		if (kind == KIND_DEC)
			dec_sent++;
		@(posedge clk);
	endtask

	// bursts of random length separated by random gaps
	task automatic pace();
		if (!src_gaps)
			return;
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end else begin
			burst_left--;
		end
	endtask

	// key words change only with the pipe empty
	task automatic load_key(tea_key_t k);
		in_ch.valid <= 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= REG_KEY0;
		wr_data  <= k.k0;
		@(posedge clk);
		wr_index <= REG_KEY1;
		wr_data  <= k.k1;
		@(posedge clk);
		wr_index <= REG_KEY2;
		wr_data  <= k.k2;
		@(posedge clk);
		wr_index <= REG_KEY3;
		wr_data  <= k.k3;
		@(posedge clk);
		wr_en <= 1'b0;
		key_shadow = k;
		key_loads++;
	endtask

	// receiver: stall rate changes from window to window, or a long hold-off on request
	initial begin
		int unsigned stall_pct;
		int unsigned win_left;
		out_ch.ready = 1'b0;
		stall_pct = 0;
		win_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (win_left == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 25;
						2: stall_pct = 50;
						default: stall_pct = 80;
					endcase
					win_left = $urandom_range(16, 200);
				end
				win_left--;
				out_ch.ready <= sink_free || ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// values are stable at the falling edge, so a handshake seen here completes at the next rise
	always @(negedge clk) begin
		blk_out_t want;
		if (arst_n) begin
			if (in_ch.valid && !in_ch.ready)
				in_stall_cycles++;
			if (out_ch.valid && out_ch.ready) begin
				if (cipher_q.size() == 0) begin
					$error("unexpected result %h %h", out_ch.out_first_word,
						out_ch.out_second_word);
					fails++;
				end else begin
					want = cipher_q.pop_front();
					results_seen++;
					if (out_ch.out_first_word !== want.y) begin
						$error("out_first_word: expected %h, got %h", want.y,
							out_ch.out_first_word);
						fails++;
					end
					if (out_ch.out_second_word !== want.z) begin
						$error("out_second_word: expected %h, got %h", want.z,
							out_ch.out_second_word);
						fails++;
					end
				end
			end
		end
	end

	initial begin
		tea_key_t k;
		// reset edge just after time zero so the flops are sure to see it
		#1;
		arst_n            = 1'b0;
		wr_en             = 1'b0;
		wr_index          = REG_KEY0;
		wr_data           = '0;
		in_ch.valid       = 1'b0;
		in_ch.kind        = KIND_ENC;
		in_ch.first_word  = '0;
		in_ch.second_word = '0;
		key_shadow        = '0;
		fails             = 0;
		blocks_sent       = 0;
		dec_sent          = 0;
		results_seen      = 0;
		key_loads         = 0;
		in_stall_cycles   = 0;
		burst_left        = 0;
		src_gaps          = 1'b1;
		sink_free         = 1'b0;
		hold_off_req      = 1'b0;

		// zero key after reset: the published all-zero vector and its inverse
		dir_tab.push_back(blk_row(KIND_ENC, 32'h0000_0000, 32'h0000_0000, 1'b1,
			32'h41EA_3A0A, 32'h94BA_A940));
		dir_tab.push_back(blk_row(KIND_DEC, 32'h41EA_3A0A, 32'h94BA_A940, 1'b1,
			32'h0000_0000, 32'h0000_0000));
		dir_tab.push_back(blk_row(KIND_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		dir_tab.push_back(blk_row(KIND_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		dir_tab.push_back(blk_row(KIND_ENC, 32'h0000_0000, 32'hFFFF_FFFF));
		dir_tab.push_back(blk_row(KIND_DEC, 32'hFFFF_FFFF, 32'h0000_0000));
		dir_tab.push_back(blk_row(KIND_ENC, 32'h8000_0000, 32'h0000_0001));
		dir_tab.push_back(blk_row(KIND_ENC, 32'hAAAA_AAAA, 32'h5555_5555));
		dir_tab.push_back(blk_row(KIND_DEC, 32'h0000_0000, 32'h0000_0000));
		dir_tab.push_back(key_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		dir_tab.push_back(blk_row(KIND_ENC, 32'h0000_0000, 32'h0000_0000));
		dir_tab.push_back(blk_row(KIND_DEC, 32'h0000_0000, 32'h0000_0000));
		dir_tab.push_back(blk_row(KIND_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		dir_tab.push_back(blk_row(KIND_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		dir_tab.push_back(key_row(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF));
		dir_tab.push_back(blk_row(KIND_ENC, 32'h1234_5678, 32'h9ABC_DEF0));
		dir_tab.push_back(blk_row(KIND_DEC, 32'h1234_5678, 32'h9ABC_DEF0));
		dir_tab.push_back(key_row(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000));
		dir_tab.push_back(blk_row(KIND_ENC, 32'h0123_4567, 32'h89AB_CDEF));
		dir_tab.push_back(blk_row(KIND_DEC, 32'h0123_4567, 32'h89AB_CDEF));
		dir_tab.push_back(key_row(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE));
		dir_tab.push_back(blk_row(KIND_ENC, 32'hFFFF_FFFF, 32'h0000_0000));
		dir_tab.push_back(blk_row(KIND_DEC, 32'h0000_0000, 32'hFFFF_FFFF));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].set_key) begin
				load_key(dir_tab[i].key);
			end else begin
				send_block(dir_tab[i].kind, dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed,
					dir_tab[i].ey, dir_tab[i].ez);
				pace();
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				2: k = '0;
				4: k = '1;
				default: k = pick_key();
			endcase
			load_key(k);
			src_gaps  = (p != 1) && (p != 3);
			sink_free = (p == 1);
			// long receiver hold-off while requests keep coming, so the pipe backs up
			if (p == 3)
				hold_off_req = 1'b1;
			repeat (PHASE_BLKS) begin
				send_block($urandom_range(0, 1) ? KIND_DEC : KIND_ENC, pick_word(),
					pick_word(), 1'b0, '0, '0);
				pace();
			end
		end

		in_ch.valid <= 1'b0;
		sink_free = 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);

		$display("%0d blocks sent (%0d decrypt), %0d results checked under %0d key settings",
			blocks_sent, dec_sent, results_seen, key_loads);
		$display("input held back for %0d cycles by output back-pressure", in_stall_cycles);
		if (fails == 0)
			$display("tea_block_cipher_tb passed");
		else
			$display("tea_block_cipher_tb failed");
		$finish;
	end

endmodule
